>>> sv/websocket_text_frame_encoder_defines.svh
// Assertion macros shared by the checker of the WebSocket frame encoder.
// Each macro expects signals named clk and arst_n in the scope of its use.
`ifndef WEBSOCKET_TEXT_FRAME_ENCODER_DEFINES_SVH
`define WEBSOCKET_TEXT_FRAME_ENCODER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define WSTE_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// An antecedent that must be followed by the given consequent sequence.
`define WSTE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) else $error(msg);

`endif

>>> sv/wste_pkg.sv
// Package for the WebSocket text frame encoder: widths, register indexes,
// header constants, the command word passed from front to back, and helpers.
package wste_pkg;

	localparam int LEN_BITS     = 16;
	localparam int KEY_BITS     = 32;
	localparam int CFG_IDX_BITS = 1;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_BITS    = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_XOR_KEY     = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_LIMIT = 1'd1;

	localparam logic [KEY_BITS-1:0] XOR_KEY_RST     = 32'h1234_5678;
	localparam logic [LEN_BITS-1:0] FRAME_LIMIT_RST = LEN_BITS'(504);

	// Header byte values.
	localparam logic [7:0] OP_TEXT_FIN = 8'h81;
	localparam logic [7:0] LEN_MASKED  = 8'h80;
	localparam logic [7:0] LEN_EXT16   = 8'hFE;
	localparam int         SHORT_MAX   = 126;

	// One command: an optional frame header plus mask, then one payload byte unless the message is empty.
	typedef struct packed {
		logic                hdr;
		logic                has_pay;
		logic [7:0]          b0;
		logic                long_len;
		logic [LEN_BITS-1:0] size;
		logic [7:0]          data;
		logic [1:0]          midx;
		logic                pay_end;
	} cmd_t;

	// Status of the command queue as seen by front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Byte positions of one command on the wire.
	typedef enum logic [8:0] {
		ST_B0  = 9'b000000001,
		ST_LEN = 9'b000000010,
		ST_LHI = 9'b000000100,
		ST_LLO = 9'b000001000,
		ST_M0  = 9'b000010000,
		ST_M1  = 9'b000100000,
		ST_M2  = 9'b001000000,
		ST_M3  = 9'b010000000,
		ST_PAY = 9'b100000000
	} step_t;

	// Mask byte k of the key, most significant byte first.
	function automatic logic [7:0] key_byte(input logic [KEY_BITS-1:0] key,
	                                        input logic [1:0] k);
		logic [7:0] b;
		case (k)
			2'd0: b = key[31:24];
			2'd1: b = key[23:16];
			2'd2: b = key[15:8];
			default: b = key[7:0];
		endcase
		return b;
	endfunction

endpackage

>>> sv/websocket_text_frame_encoder.sv
// Top level of the WebSocket client text frame encoder: configuration
// registers, front, command queue and back. Depends on wste_pkg.
//
//  channel | handshake           | word
//  --------+---------------------+--------------------------------------
//  input   | push / full         | data_byte, msg_length, msg_start
//  result  | empty / pop         | out_byte, frame_end, run_last
//  config  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A payload byte that continues a frame gives one wire byte at the back; a byte that
// opens a frame also gives the header (two bytes, four with a 16-bit length) and four mask bytes.
// The front accepts one word per cycle until the 4-entry command queue fills.
// A result word is held in a command queue entry and then in the output register.
// Reset clears all control state; no clearing pass is needed.
// cfg_ready is always high.
module websocket_text_frame_encoder import wste_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [7:0]              data_byte,
	input  logic [LEN_BITS-1:0]     msg_length,
	input  logic                    msg_start,
	output logic                    empty,
	input  logic                    pop,
	output logic [7:0]              out_byte,
	output logic                    frame_end,
	output logic                    run_last,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [KEY_BITS-1:0]     cfg_data
);

	logic [KEY_BITS-1:0] xor_key_q;
	logic [LEN_BITS-1:0] frame_limit_q;
	qstat_t              qstat;
	cmd_t                cmd;
	cmd_t                head;
	logic                cmd_push;
	logic                q_pop;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_key_q     <= XOR_KEY_RST;
			frame_limit_q <= FRAME_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_XOR_KEY:     xor_key_q     <= cfg_data;
				REG_FRAME_LIMIT: frame_limit_q <= cfg_data[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	wste_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.data_byte   (data_byte),
		.msg_length  (msg_length),
		.msg_start   (msg_start),
		.frame_limit (frame_limit_q),
		.qstat       (qstat),
		.full        (full),
		.cmd_push    (cmd_push),
		.cmd         (cmd)
	);

	wste_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd),
		.rd_en  (q_pop),
		.head   (head),
		.qstat  (qstat)
	);

	wste_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.xor_key   (xor_key_q),
		.pop       (pop),
		.q_pop     (q_pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.frame_end (frame_end),
		.run_last  (run_last)
	);

endmodule

>>> sv/wste_front.sv
// Front of the frame encoder: accepts input words, tracks message and frame
// position, and turns each word of a message into one command. Depends on wste_pkg.
module wste_front import wste_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          data_byte,
	input  logic [LEN_BITS-1:0] msg_length,
	input  logic                msg_start,
	input  logic [LEN_BITS-1:0] frame_limit,
	input  qstat_t              qstat,
	output logic                full,
	output logic                cmd_push,
	output cmd_t                cmd
);

	logic [LEN_BITS-1:0] message_left_q;
	logic [LEN_BITS-1:0] frame_left_q;
	logic [1:0]          mask_index_q;
	logic                fragmented_q;
	logic                first_done_q;

	logic                accept;
	logic                active;
	logic                empty_msg;
	logic                new_frame;
	logic                last_frag;
	logic [LEN_BITS-1:0] lim;
	logic [LEN_BITS-1:0] ml_e;
	logic [LEN_BITS-1:0] fl_e;
	logic [1:0]          mi_e;
	logic                frag_e;
	logic                ffd_e;
	logic [LEN_BITS-1:0] size;
	logic [7:0]          b0;
	logic                long_len;
	logic [LEN_BITS-1:0] fl_h;
	logic [1:0]          mi_h;
	logic [LEN_BITS-1:0] fl_n;
	logic [LEN_BITS-1:0] ml_n;

	assign full     = qstat.full;
	assign accept   = push && !qstat.full;
	assign cmd_push = accept && active;

	// Classify the word against the current message and frame position.
	always_comb begin
		lim       = (frame_limit == '0) ? LEN_BITS'(1) : frame_limit;
		empty_msg = msg_start && (msg_length == '0);
		active    = msg_start || (message_left_q != '0);
		ml_e      = msg_start ? msg_length : message_left_q;
		fl_e      = msg_start ? '0 : frame_left_q;
		mi_e      = msg_start ? 2'd0 : mask_index_q;
		frag_e    = msg_start ? (msg_length >= lim) : fragmented_q;
		ffd_e     = msg_start ? 1'b0 : first_done_q;
		new_frame = (fl_e == '0);
		last_frag = (ml_e <= lim);

		if (frag_e) begin
			size     = last_frag ? ml_e : lim;
			b0       = {last_frag, 6'b0, !ffd_e};
			long_len = 1'b1;
		end else begin
			size     = ml_e;
			b0       = OP_TEXT_FIN;
			long_len = (ml_e >= LEN_BITS'(SHORT_MAX));
		end

		fl_h = new_frame ? size : fl_e;
		mi_h = new_frame ? 2'd0 : mi_e;
		fl_n = fl_h - LEN_BITS'(1);
		ml_n = ml_e - LEN_BITS'(1);

		cmd.hdr      = empty_msg || new_frame;
		cmd.has_pay  = !empty_msg;
		cmd.b0       = empty_msg ? OP_TEXT_FIN : b0;
		cmd.long_len = empty_msg ? 1'b0 : long_len;
		cmd.size     = empty_msg ? '0 : size;
		cmd.data     = data_byte;
		cmd.midx     = mi_h;
		cmd.pay_end  = (fl_n == '0);
	end

	// Message and frame position state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			message_left_q <= '0;
			frame_left_q   <= '0;
			mask_index_q   <= 2'd0;
			fragmented_q   <= 1'b0;
			first_done_q   <= 1'b0;
		end else if (accept && empty_msg) begin
			message_left_q <= '0;
			frame_left_q   <= '0;
			mask_index_q   <= 2'd0;
			fragmented_q   <= 1'b0;
			first_done_q   <= 1'b1;
		end else if (accept && active) begin
			message_left_q <= ml_n;
			frame_left_q   <= fl_n;
			mask_index_q   <= mi_h + 2'd1;
			fragmented_q   <= frag_e;
			first_done_q   <= 1'b1;
		end
	end

endmodule

>>> sv/wste_cmd_queue.sv
// Short command queue between the front and back of the frame encoder.
// Register based, one write and one read per cycle. Depends on wste_pkg.
module wste_cmd_queue import wste_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  cmd_t   wr_cmd,
	input  logic   rd_en,
	output cmd_t   head,
	output qstat_t qstat
);

	cmd_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (QPTR_BITS+1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (QPTR_BITS+1)'(1);
			end
		end
	end

endmodule

>>> sv/wste_back.sv
// Back of the frame encoder: expands each queued command into wire bytes
// (header, mask, masked payload) into an output register. Depends on wste_pkg.
module wste_back import wste_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                head,
	input  qstat_t              qstat,
	input  logic [KEY_BITS-1:0] xor_key,
	input  logic                pop,
	output logic                q_pop,
	output logic                empty,
	output logic [7:0]          out_byte,
	output logic                frame_end,
	output logic                run_last
);

	logic       active_q;
	step_t      step_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       frame_end_q;
	logic       run_last_q;

	step_t      cur_step;
	step_t      nxt_step;
	logic       emit;
	logic       last;
	logic       fend;
	logic [7:0] wire_byte;
	logic [15:0] size16;

	assign empty     = !out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;
	assign emit      = !qstat.empty && (!out_valid_q || pop);
	assign q_pop     = emit && last;

	// Pick the byte for the current position of the head command.
	always_comb begin
		size16   = 16'(head.size);
		cur_step = active_q ? step_q : (head.hdr ? ST_B0 : ST_PAY);
		last     = 1'b0;
		fend     = 1'b0;
		case (cur_step)
			ST_B0: begin
				wire_byte = head.b0;
				nxt_step  = ST_LEN;
			end
			ST_LEN: begin
				wire_byte = head.long_len ? LEN_EXT16 : (LEN_MASKED | {1'b0, size16[6:0]});
				nxt_step  = head.long_len ? ST_LHI : ST_M0;
			end
			ST_LHI: begin
				wire_byte = size16[15:8];
				nxt_step  = ST_LLO;
			end
			ST_LLO: begin
				wire_byte = size16[7:0];
				nxt_step  = ST_M0;
			end
			ST_M0: begin
				wire_byte = key_byte(xor_key, 2'd0);
				nxt_step  = ST_M1;
			end
			ST_M1: begin
				wire_byte = key_byte(xor_key, 2'd1);
				nxt_step  = ST_M2;
			end
			ST_M2: begin
				wire_byte = key_byte(xor_key, 2'd2);
				nxt_step  = ST_M3;
			end
			ST_M3: begin
				wire_byte = key_byte(xor_key, 2'd3);
				nxt_step  = ST_PAY;
				last      = !head.has_pay;
				fend      = !head.has_pay;
			end
			ST_PAY: begin
				wire_byte = head.data ^ key_byte(xor_key, head.midx);
				nxt_step  = ST_B0;
				last      = 1'b1;
				fend      = head.pay_end;
			end
			default: begin
				wire_byte = 8'h00;
				nxt_step  = ST_B0;
			end
		endcase
	end

	// Sequencer position within the head command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= ST_B0;
		end else if (emit) begin
			active_q <= !last;
			step_q   <= nxt_step;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register word.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= wire_byte;
			frame_end_q <= fend;
			run_last_q  <= last;
		end
	end

endmodule

>>> sv/wste_checker.sv
// Port-level checker for the frame encoder, bound to the top level.
// Depends on wste_pkg and the assertion macros header.
`include "websocket_text_frame_encoder_defines.svh"

module wste_checker import wste_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input logic [LEN_BITS-1:0] msg_length,
	input logic                msg_start,
	input logic                empty,
	input logic                pop,
	input logic [7:0]          out_byte,
	input logic                frame_end,
	input logic                run_last
);

	// A stalled result word holds.
	`WSTE_ASSERT_IMP(a_hold, !empty && !pop, ##1 (!empty && $stable(out_byte) && $stable(frame_end) && $stable(run_last)), "result word changed while stalled")

	// An accepted start of a message, empty or not, is followed by a result word in the output register.
	`WSTE_ASSERT_IMP(a_start_out, push && !full && msg_start && (msg_length == msg_length), ##2 (!empty), "started message gave no result in time")

	// The queue can only fill while the output register holds a word.
	`WSTE_ASSERT(a_full_empty, !(full && empty), "input full while output empty")

	// A frame always ends on the last byte of its input word.
	`WSTE_ASSERT(a_end_last, empty || !frame_end || run_last, "frame ended before last byte of word")

endmodule

bind websocket_text_frame_encoder wste_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.msg_length (msg_length),
	.msg_start  (msg_start),
	.empty      (empty),
	.pop        (pop),
	.out_byte   (out_byte),
	.frame_end  (frame_end),
	.run_last   (run_last)
);
